// ===== sv/ntpcal_pkg.sv =====
// ----------------------------------------------------------------------------
// ntpcal_pkg
// Types and constants shared by the seconds-to-calendar pipeline.
// ----------------------------------------------------------------------------
package ntpcal_pkg;

  localparam int unsigned SecWidth    = 32;
  localparam int unsigned OffWidth    = 6;
  localparam int unsigned DayWidth    = 16;
  localparam int unsigned TodWidth    = 17;
  localparam int unsigned DaysTo2009  = 39812;
  localparam int unsigned SecPerDay   = 86400;
  localparam int unsigned SecPerHour  = 3600;
  localparam int unsigned DaysPerQuad = 1461;
  localparam int unsigned FirstYear   = 9;
  localparam int unsigned LastYear    = 99;

  typedef logic [SecWidth-1:0] sec_t;
  typedef logic signed [OffWidth-1:0] off_t;

  typedef struct packed {
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
    logic       out_of_range;
  } cal_t;

  // Packed BCD of a value below 100. The tens digit is v * 205 / 2048,
  // which is exact for every 7-bit value.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  r;
    p = 15'(v) * 15'd205;
    tens = p[14:11];
    r = v - 7'(tens) * 7'd10;
    return {tens, r[3:0]};
  endfunction

endpackage

// ===== sv/ntpcal_if.sv =====
// ----------------------------------------------------------------------------
// ntpcal stream interfaces
// Valid/ready channels for seconds in, calendar out and offset writes.
// ----------------------------------------------------------------------------
interface ntpcal_in_if;
  logic                 valid;
  logic                 ready;
  ntpcal_pkg::sec_t     ntp_seconds;
  modport source(output valid, output ntp_seconds, input ready);
  modport sink(input valid, input ntp_seconds, output ready);
endinterface

interface ntpcal_out_if;
  logic                 valid;
  logic                 ready;
  ntpcal_pkg::cal_t     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ntpcal_cfg_if;
  logic                 valid;
  logic                 ready;
  ntpcal_pkg::off_t     utc_offset_hours;
  modport source(output valid, output utc_offset_hours, input ready);
  modport sink(input valid, input utc_offset_hours, output ready);
endinterface

// ===== sv/ntpcal_daysplit.sv =====
// ----------------------------------------------------------------------------
// ntpcal_daysplit
// Stages 1-3: offset add, then days and seconds of day by reciprocal divide.
// ----------------------------------------------------------------------------
module ntpcal_daysplit (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  ntpcal_pkg::sec_t    in_sec,
  input  ntpcal_pkg::off_t    offset,
  output logic                out_valid,
  output logic [ntpcal_pkg::DayWidth-1:0] days,
  output logic [ntpcal_pkg::TodWidth-1:0] tod
);
  import ntpcal_pkg::*;

  // 2^48 / 86400 rounded up; the check below corrects a quotient that is one low.
  localparam logic [32:0] Recip = 33'((64'd1 << 48) / SecPerDay + 1);

  logic        v1;
  sec_t        sec1;
  logic        v2;
  sec_t        sec2;
  logic [65:0] prod;
  logic [15:0] q2;
  logic [15:0] qn;
  logic [32:0] r_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  assign prod = {33'd0, sec1} * {33'd0, Recip};

  always_ff @(posedge clk) begin
    if (en) begin
      sec1 <= in_sec + sec_t'($signed({{(SecWidth-OffWidth){offset[OffWidth-1]}}, offset})
                      * $signed(SecWidth'(SecPerHour)));
      sec2 <= sec1;
      q2   <= prod[63:48];
    end
  end

  always_comb begin
    r_calc = {1'b0, sec2} - 33'(q2) * 33'(SecPerDay);
    qn = q2;
    if (r_calc >= 33'(SecPerDay)) begin
      r_calc = r_calc - 33'(SecPerDay);
      qn = q2 + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      days <= qn;
      tod  <= r_calc[TodWidth-1:0];
    end
  end
endmodule

// ===== sv/ntpcal_date.sv =====
// ----------------------------------------------------------------------------
// ntpcal_date
// Stages 4-8: four-year blocks and minutes, day in block and hours, year
// and remainders, month lookup, BCD packing.
// ----------------------------------------------------------------------------
module ntpcal_date (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [ntpcal_pkg::DayWidth-1:0] days,
  input  logic [ntpcal_pkg::TodWidth-1:0] tod,
  output logic                out_valid,
  output ntpcal_pkg::cal_t    result
);
  import ntpcal_pkg::*;

  // Rounded-up reciprocals; each quotient is exact over the operand range.
  localparam logic [15:0] RecipQuad = 16'd45934;   // 2^26 / 1461
  localparam logic [17:0] RecipMin  = 18'd139811;  // 2^23 / 60
  localparam logic [12:0] RecipHour = 13'd4370;    // 2^18 / 60

  logic        v3, v4, v5, v6;
  logic        bad3, bad4, bad5, bad6;
  logic [15:0] rel3;
  logic [5:0]  quad3, quad4;
  logic [10:0] mins3, mins4;
  logic [16:0] tod3;
  logic [10:0] inq4;
  logic [4:0]  hr4, hr5, hr6;
  logic [5:0]  se4, se5, se6;
  logic [5:0]  mi5, mi6;
  logic [6:0]  yr5, yr6;
  logic        leap5;
  logic [8:0]  doy5;
  logic [3:0]  mon6;
  logic [4:0]  dom6;

  logic [15:0] rel;
  logic [31:0] quad_prod;
  logic [34:0] min_prod;
  logic [10:0] inq;
  logic [22:0] hr_prod;
  logic [16:0] se_full;
  logic [1:0]  yq;
  logic [10:0] yq_days;
  logic [8:0]  yr;
  logic [10:0] mi_full;
  logic [3:0]  mon;
  logic [8:0]  mstart;

  // First day of month m (0 = January) within the year.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && m >= 4'd2) s = s + 9'd1;
    return s;
  endfunction

  // Blocks of four years start at 2009: three common years, then a leap year.
  always_comb begin
    rel = days - 16'(DaysTo2009);
    quad_prod = 32'(rel) * 32'(RecipQuad);
    min_prod = 35'(tod) * 35'(RecipMin);
  end

  always_comb begin
    inq = 11'(rel3 - 16'(quad3) * 16'(DaysPerQuad));
    hr_prod = 23'(mins3) * 23'(RecipHour);
    se_full = tod3 - 17'(mins3) * 17'd60;
  end

  always_comb begin
    if (inq4 >= 11'd1095) begin
      yq = 2'd3; yq_days = 11'd1095;
    end else if (inq4 >= 11'd730) begin
      yq = 2'd2; yq_days = 11'd730;
    end else if (inq4 >= 11'd365) begin
      yq = 2'd1; yq_days = 11'd365;
    end else begin
      yq = 2'd0; yq_days = 11'd0;
    end
    yr = 9'(FirstYear) + {1'b0, quad4, 2'b00} + 9'(yq);
    mi_full = mins4 - 11'(hr4) * 11'd60;
  end

  always_comb begin
    mon = 4'd1;
    mstart = 9'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy5 >= month_start(4'(m), leap5)) begin
        mon = 4'(m + 1);
        mstart = month_start(4'(m), leap5);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v3 <= in_valid; v4 <= v3; v5 <= v4; v6 <= v5; out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad3 <= (days < 16'(DaysTo2009));
      rel3 <= rel; quad3 <= quad_prod[31:26];
      mins3 <= min_prod[33:23]; tod3 <= tod;

      bad4 <= bad3; quad4 <= quad3; inq4 <= inq;
      mins4 <= mins3; hr4 <= hr_prod[22:18]; se4 <= se_full[5:0];

      bad5 <= bad4 || (yr > 9'(LastYear));
      yr5 <= yr[6:0]; leap5 <= (yq == 2'd3);
      doy5 <= 9'(inq4 - yq_days);
      hr5 <= hr4; mi5 <= mi_full[5:0]; se5 <= se4;

      bad6 <= bad5; yr6 <= yr5;
      mon6 <= mon; dom6 <= 5'(doy5 - mstart + 9'd1);
      hr6 <= hr5; mi6 <= mi5; se6 <= se5;

      result.year_bcd   <= bad6 ? 8'd0 : to_bcd(yr6);
      result.month_bcd  <= bad6 ? 5'd0 : 5'(to_bcd({3'd0, mon6}));
      result.day_bcd    <= bad6 ? 6'd0 : 6'(to_bcd({2'd0, dom6}));
      result.hour_bcd   <= 6'(to_bcd({2'd0, hr6}));
      result.minute_bcd <= 7'(to_bcd({1'b0, mi6}));
      result.second_bcd <= 7'(to_bcd({1'b0, se6}));
      result.out_of_range <= bad6;
    end
  end
endmodule

// ===== sv/ntp_seconds_to_bcd_calendar_core.sv =====
// ----------------------------------------------------------------------------
// ntp_seconds_to_bcd_calendar_core
// NTP seconds to local BCD calendar date and time.
// ----------------------------------------------------------------------------
// Usage: push 32-bit NTP seconds on the input channel; one calendar result
// leaves the output channel per input transaction, in order. The signed
// whole-hour UTC offset is written on the configuration channel while idle;
// it is always ready.
// Each item passes through the eight-stage pipeline (offset add, day
// divide, correction, year blocks and minutes, day in block and hours,
// year and remainders, month, BCD output register). One item can enter
// every cycle while the receiver takes results; the rate is then one item
// per cycle.
// Dates before 2009 or from 2100 on set out_of_range and zero the date.
// Reset clears all valid bits and sets the offset to zero. When the
// receiver stalls, the whole pipeline holds and input ready drops.
// ----------------------------------------------------------------------------
module ntp_seconds_to_bcd_calendar_core (
  input logic clk,
  input logic rst,
  ntpcal_in_if.sink    in_ch,
  ntpcal_out_if.source out_ch,
  ntpcal_cfg_if.sink   cfg
);
  import ntpcal_pkg::*;

  off_t offset;
  logic en;
  logic v_mid;
  logic [DayWidth-1:0] days;
  logic [TodWidth-1:0] tod;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) offset <= '0;
    else if (cfg.valid) offset <= cfg.utc_offset_hours;
  end

  ntpcal_daysplit u_split (
    .clk, .rst, .en,
    .in_valid(in_ch.valid), .in_sec(in_ch.ntp_seconds), .offset,
    .out_valid(v_mid), .days, .tod
  );

  ntpcal_date u_date (
    .clk, .rst, .en,
    .in_valid(v_mid), .days, .tod,
    .out_valid(out_ch.valid), .result(out_ch.data)
  );
endmodule

// ===== sv/ntpcal_checker.sv =====
// ----------------------------------------------------------------------------
// ntpcal_checker
// Port-level checks of the calendar core, bound to the top level.
// ----------------------------------------------------------------------------
module ntpcal_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input ntpcal_pkg::cal_t data
);
  import ntpcal_pkg::*;

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready not tied to output progress");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && data.out_of_range |-> data.year_bcd == 8'd0 && data.month_bcd == 5'd0)
    else $error("out-of-range date not cleared");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("offered transaction withdrawn");
  a_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind ntp_seconds_to_bcd_calendar_core ntpcal_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .data(out_ch.data)
);

// ===== verif/ntp_seconds_to_bcd_calendar_core_test.sv =====
// ----------------------------------------------------------------------------
// ntp_seconds_to_bcd_calendar_core_test
// Drives NTP seconds through the calendar core under random idling and
// stalls, predicts each local BCD date and time, and checks every result.
// ----------------------------------------------------------------------------
module ntp_seconds_to_bcd_calendar_core_test;
  import ntpcal_pkg::*;

  class calendar_board;
    cal_t pending[$];
    int errors = 0;

    function logic [7:0] bcd(int unsigned v);
      return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function cal_t convert(sec_t secs, off_t off);
      cal_t c;
      sec_t s;
      int unsigned days, rem, yr, mo, diy, md;
      bit found;
      s = secs + sec_t'(int'(off) * 3600);
      days = s / 86400;
      c = '0;
      c.out_of_range = 1'b1;
      if (days >= 39812) begin
        rem = days - 39812;
        found = 0;
        for (yr = 9; yr <= 99; yr++) begin
          diy = (yr % 4) ? 365 : 366;
          if (rem < diy) begin
            found = 1;
            break;
          end
          rem -= diy;
        end
        if (found) begin
          for (mo = 0; mo < 11; mo++) begin
            case (mo)
              1: md = (yr % 4 == 0) ? 29 : 28;
              3, 5, 8, 10: md = 30;
              default: md = 31;
            endcase
            if (rem < md) break;
            rem -= md;
          end
          c.out_of_range = 1'b0;
          c.year_bcd = bcd(yr);
          c.month_bcd = 5'(bcd(mo + 1));
          c.day_bcd = 6'(bcd(rem + 1));
        end
      end
      c.hour_bcd = 6'(bcd((s / 3600) % 24));
      c.minute_bcd = 7'(bcd((s / 60) % 60));
      c.second_bcd = 7'(bcd(s % 60));
      return c;
    endfunction

    function void note_input(sec_t secs, off_t off);
      pending.push_back(convert(secs, off));
    endfunction

    function void check_result(cal_t got);
      cal_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.year_bcd !== e.year_bcd) begin
        $error("year_bcd exp %h got %h", e.year_bcd, got.year_bcd); errors++;
      end
      if (got.month_bcd !== e.month_bcd) begin
        $error("month_bcd exp %h got %h", e.month_bcd, got.month_bcd); errors++;
      end
      if (got.day_bcd !== e.day_bcd) begin
        $error("day_bcd exp %h got %h", e.day_bcd, got.day_bcd); errors++;
      end
      if (got.hour_bcd !== e.hour_bcd) begin
        $error("hour_bcd exp %h got %h", e.hour_bcd, got.hour_bcd); errors++;
      end
      if (got.minute_bcd !== e.minute_bcd) begin
        $error("minute_bcd exp %h got %h", e.minute_bcd, got.minute_bcd); errors++;
      end
      if (got.second_bcd !== e.second_bcd) begin
        $error("second_bcd exp %h got %h", e.second_bcd, got.second_bcd); errors++;
      end
      if (got.out_of_range !== e.out_of_range) begin
        $error("out_of_range exp %b got %b", e.out_of_range, got.out_of_range);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  ntpcal_in_if in_ch();
  ntpcal_out_if out_ch();
  ntpcal_cfg_if cfg();

  ntp_seconds_to_bcd_calendar_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  calendar_board board = new();
  off_t offset = '0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.ntp_seconds = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.utc_offset_hours = '0;
  end

  // Receiver: random idling, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Valid stays high between back-to-back transactions and drops on idling.
  task automatic send_item(sec_t secs);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ntp_seconds <= secs;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(secs, offset);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_offset(off_t v);
    drain();
    cfg.valid <= 1'b1;
    cfg.utc_offset_hours <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    offset = v;
  endtask

  // Mostly dates inside the valid span; the rest are anywhere, near the 2009 start, or near the top.
  function automatic sec_t random_seconds();
    case ($urandom_range(9))
      0, 1: return $urandom();
      2: return 32'd3439756800 + sec_t'($urandom_range(200000)) - 32'd100000;
      3: return 32'hFFFF_FFFF - sec_t'($urandom_range(200000));
      default: return 32'd3439756800 + sec_t'($urandom_range(32'd855187200));
    endcase
  endfunction

  initial begin
    off_t offs[7] = '{6'sd0, 6'sd24, -6'sd24, 6'sd31, 6'sh20, 6'sd5, -6'sd9};
    sec_t dir[$] = '{32'h0, 32'hFFFF_FFFF, 32'd3439756799, 32'd3439756800,
                     32'd3455740800, 32'd3456000000, 32'd3460464000,
                     32'd3786825599, 32'd3582403200, 32'd3585081599,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (offs[k]) begin
      if (k > 0) write_offset(offs[k]);
      case (k)
        0, 1: begin send_idle = 28; recv_idle = 49; end
        2, 3: begin send_idle = 49; recv_idle = 28; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (k == 0 || k == 3 || k == 4)
        foreach (dir[i]) send_item(dir[i]);
      for (int n = 0; n < 80; n++) begin
        if (n == 40 && k == 5) hold_cycles <= 300;
        if (n == 60 && k == 2) drain();
        send_item(random_seconds());
      end
    end
    write_offset(-6'sd1);
    repeat (40) send_item(random_seconds());
    drain();
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ntpcal_pkg.sv
sv/ntpcal_if.sv
sv/ntpcal_daysplit.sv
sv/ntpcal_date.sv
sv/ntp_seconds_to_bcd_calendar_core.sv
sv/ntpcal_checker.sv
verif/ntp_seconds_to_bcd_calendar_core_test.sv
